/* design/mr180_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mr180_pkg
// Shared types, codes and helpers for the 180-degree mask rotator.
// ----------------------------------------------------------------------------
package mr180_pkg;

    // Configuration registers are 9 bits at most; dimensions are 9 bits.
    localparam int DIM_W     = 9;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Mask modes. The fourth code behaves as alpha.
    localparam logic [MODE_W-1:0] MODE_ALPHA    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO_MSB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONO_LSB = 2'd2;

    // Item opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] source_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // write the accepted byte into the source store
        logic rd_hi;    // resolve the address and read the first source byte
        logic rd_lo;    // read the second source byte of a mono fetch
        logic finish;   // result goes to the output register, advance position
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_lo;  // the fetch needs a second source byte
    } status_t;

    function automatic logic [7:0] bit_rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/mr180_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mr180_ctrl
// Sequencer: accepts items, steps a fetch through its source reads and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module mr180_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  item_valid,
    input  wire                  item_opcode,
    input  wire                  out_free,
    input  wire mr180_pkg::status_t status,
    output logic                 item_ready,
    output mr180_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_READ_HI = 4'b0010,
        ST_READ_LO = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                cmd.load   = item_valid && (item_opcode == mr180_pkg::OP_LOAD);
                if (item_valid && (item_opcode == mr180_pkg::OP_FETCH)) begin
                    state_next = ST_READ_HI;
                end
            end
            ST_READ_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = status.need_lo ? ST_READ_LO : ST_FINISH;
            end
            ST_READ_LO: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* design/mr180_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mr180_dp
// Datapath: source store, load and fetch position counters, address
// generation and assembly of the rotated output byte.
// ----------------------------------------------------------------------------
module mr180_dp #(
    parameter int DEPTH = 65536
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire mr180_pkg::cfg_t cfg,
    input  wire                  restart,
    input  wire  [7:0]           load_byte,
    input  wire mr180_pkg::cmd_t cmd,
    output mr180_pkg::status_t   status,
    output mr180_pkg::out_item_t result
);

    localparam int DIM_W  = mr180_pkg::DIM_W;
    localparam int PROD_W = mr180_pkg::PROD_W;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] store_mem [DEPTH];

    logic              mono;
    logic              msb_first;
    logic [DIM_W-1:0]  row_bytes;
    logic [DIM_W-1:0]  stride;

    assign mono      = (cfg.mode == mr180_pkg::MODE_MONO_MSB) ||
                       (cfg.mode == mr180_pkg::MODE_MONO_LSB);
    assign msb_first = (cfg.mode == mr180_pkg::MODE_MONO_MSB);
    assign row_bytes = DIM_W'((PROD_W'(cfg.width) + PROD_W'(7)) >> 3);
    assign stride    = mono ? row_bytes : cfg.width;

    // Start address of the last source row, the first one read in a frame.
    logic [PROD_W-1:0] init_prod;
    logic [ADDR_W-1:0] init_base_reg;

    assign init_prod = PROD_W'(cfg.height - DIM_W'(1)) * PROD_W'(stride);

    always_ff @(posedge aclk) begin
        init_base_reg <= init_prod[ADDR_W-1:0];
    end

    // Load side.
    logic [ADDR_W-1:0] load_addr_reg;
    logic [DIM_W-1:0]  load_col_reg;
    logic [DIM_W-1:0]  load_row_reg;
    logic              load_full;
    logic              load_we;

    assign load_full = (load_row_reg == cfg.height);
    assign load_we   = cmd.load && !load_full;

    // Fetch side.
    logic [DIM_W-1:0]  fx_reg, fy_reg;
    logic              first_row_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [ADDR_W-1:0] base;
    logic              row_end;
    logic              frame_end;

    assign base      = first_row_reg ? init_base_reg : row_base_reg;
    assign row_end   = (fx_reg == cfg.width - DIM_W'(1));
    assign frame_end = row_end && (fy_reg == cfg.height - DIM_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_addr_reg <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            first_row_reg <= 1'b1;
        end else if (restart || (cmd.finish && frame_end)) begin
            load_addr_reg <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            first_row_reg <= 1'b1;
        end else begin
            if (load_we) begin
                load_addr_reg <= load_addr_reg + ADDR_W'(1);
                if (load_col_reg == stride - DIM_W'(1)) begin
                    load_col_reg <= '0;
                    load_row_reg <= load_row_reg + DIM_W'(1);
                end else begin
                    load_col_reg <= load_col_reg + DIM_W'(1);
                end
            end
            if (cmd.finish) begin
                if (row_end) begin
                    fx_reg        <= '0;
                    fy_reg        <= fy_reg + DIM_W'(1);
                    first_row_reg <= 1'b0;
                end else begin
                    fx_reg <= fx_reg + DIM_W'(1);
                end
            end
        end
    end

    // Moving up one source row per output row.
    logic [PROD_W-1:0] up_sum;
    assign up_sum = PROD_W'(base) - PROD_W'(stride);

    always_ff @(posedge aclk) begin
        if (cmd.finish && row_end) begin
            row_base_reg <= up_sum[ADDR_W-1:0];
        end
    end

    // Address generation. In mono modes t is the source pixel index of output
    // bit zero; the byte holding it and the one before cover all eight bits.
    logic [11:0]       x8;
    logic [11:0]       t_val;
    logic [DIM_W-1:0]  hi_idx;
    logic [DIM_W-1:0]  lo_idx;
    logic              beyond;
    logic [DIM_W-1:0]  alpha_off;
    logic [PROD_W-1:0] hi_sum;
    logic [PROD_W-1:0] lo_sum;
    logic [ADDR_W-1:0] hi_addr;
    logic [7:0]        bit_mask;

    assign x8        = {fx_reg, 3'b000};
    assign t_val     = 12'(cfg.width) - 12'd1 - x8;
    assign hi_idx    = t_val[11:3];
    assign lo_idx    = (hi_idx == '0) ? hi_idx : hi_idx - DIM_W'(1);
    assign beyond    = (x8 >= 12'(cfg.width));
    assign alpha_off = cfg.width - DIM_W'(1) - fx_reg;
    assign hi_sum    = PROD_W'(base) + PROD_W'(mono ? hi_idx : alpha_off);
    assign lo_sum    = PROD_W'(base) + PROD_W'(lo_idx);
    assign hi_addr   = hi_sum[ADDR_W-1:0];
    assign bit_mask  = (t_val >= 12'd7) ? 8'hFF : 8'((9'd2 << t_val[2:0]) - 9'd1);

    assign status.need_lo = mono && !beyond;

    logic [ADDR_W-1:0] lo_addr_reg;
    logic [2:0]        t_lo_reg;
    logic [7:0]        mask_reg;
    logic              zero_reg;
    logic [7:0]        hi_byte_reg;
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    assign rd_addr = cmd.rd_lo ? lo_addr_reg : hi_addr;

    // The read data is only refreshed by the read steps, so it holds while
    // the finished byte waits for the output register.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            store_mem[load_addr_reg] <= load_byte;
        end
        if (cmd.rd_hi || cmd.rd_lo) begin
            rdata_reg <= store_mem[rd_addr];
        end
        if (cmd.rd_hi) begin
            lo_addr_reg <= lo_sum[ADDR_W-1:0];
            t_lo_reg    <= t_val[2:0];
            mask_reg    <= bit_mask;
            zero_reg    <= mono && beyond;
        end
        if (cmd.rd_lo) begin
            hi_byte_reg <= rdata_reg;
        end
    end

    // Output assembly: both bytes in LSB-first pixel order form a 16-bit
    // window; output bit k takes window bit t_lo + 8 - k.
    logic [15:0] window;
    logic [15:0] shifted;
    logic [7:0]  acc;
    logic [7:0]  mono_byte;

    assign window    = msb_first ?
                       {mr180_pkg::bit_rev8(hi_byte_reg), mr180_pkg::bit_rev8(rdata_reg)} :
                       {hi_byte_reg, rdata_reg};
    assign shifted   = window >> ({1'b0, t_lo_reg} + 4'd1);
    assign acc       = mr180_pkg::bit_rev8(shifted[7:0]) & mask_reg;
    assign mono_byte = msb_first ? mr180_pkg::bit_rev8(acc) : acc;

    assign result.out_byte  = zero_reg ? 8'h00 : (mono ? mono_byte : rdata_reg);
    assign result.last_byte = frame_end;

endmodule
`default_nettype wire

/* design/mask_rotate_180.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mask_rotate_180
// Rotates a glyph mask (8-bit alpha or 1-bit packed) by 180 degrees.
// ----------------------------------------------------------------------------
// Load transfers (opcode 0) write the source window into an on-chip store in
// raster order, one byte per cycle while no fetch is in progress; loads past
// the window size are dropped. Each fetch transfer (opcode 1) returns the next
// byte of the rotated buffer, mask_height rows of mask_width bytes, with
// last_byte set on the final one. The single read port of the source store is
// used once per alpha byte and twice per mono byte, and the store read data
// is registered. Mono output bytes past the packed row are zero and use the
// read port only once. A finished byte waits in the output register, so the
// next transfer is accepted while it is unclaimed. Any write to a defined
// register restarts both the load and fetch positions, as does finishing the
// final byte of a frame. Configuration is written only while no transfer is
// in progress, which the user must ensure; the block does not enforce it.
// The store is not cleared at reset.
// ----------------------------------------------------------------------------
module mask_rotate_180 #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Input channel.
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire mr180_pkg::in_item_t             s_data,
    // Result channel.
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output mr180_pkg::out_item_t                 m_data,
    // Configuration write port.
    input  wire                                  cfg_we,
    input  wire  [mr180_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mr180_pkg::DIM_W-1:0]          cfg_wdata
);

    localparam int DIM_W = mr180_pkg::DIM_W;
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    // A 9-bit register cannot exceed DIM_MAX, so the store never needs more.
    localparam int WIDTH_CAP  = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int HEIGHT_CAP = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int DEPTH      = WIDTH_CAP * HEIGHT_CAP;

    // Configuration registers, with width and height saturated into range.
    mr180_pkg::cfg_t  cfg_reg;
    logic             restart;
    logic [DIM_W-1:0] width_sat;
    logic [DIM_W-1:0] height_sat;

    assign width_sat  = (cfg_wdata == '0) ? DIM_W'(1) :
                        (cfg_wdata > DIM_W'(WIDTH_CAP)) ? DIM_W'(WIDTH_CAP) : cfg_wdata;
    assign height_sat = (cfg_wdata == '0) ? DIM_W'(1) :
                        (cfg_wdata > DIM_W'(HEIGHT_CAP)) ? DIM_W'(HEIGHT_CAP) : cfg_wdata;
    assign restart    = cfg_we && ((cfg_index == mr180_pkg::REG_MODE) ||
                                   (cfg_index == mr180_pkg::REG_WIDTH) ||
                                   (cfg_index == mr180_pkg::REG_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= mr180_pkg::MODE_ALPHA;
            cfg_reg.width  <= DIM_W'(1);
            cfg_reg.height <= DIM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                mr180_pkg::REG_MODE:   cfg_reg.mode   <= cfg_wdata[mr180_pkg::MODE_W-1:0];
                mr180_pkg::REG_WIDTH:  cfg_reg.width  <= width_sat;
                mr180_pkg::REG_HEIGHT: cfg_reg.height <= height_sat;
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // Controller and datapath.
    mr180_pkg::cmd_t      cmd;
    mr180_pkg::status_t   status;
    mr180_pkg::out_item_t result;
    logic                 out_free;

    mr180_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_valid),
        .item_opcode (s_data.opcode),
        .out_free    (out_free),
        .status      (status),
        .item_ready  (s_ready),
        .cmd         (cmd)
    );

    mr180_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .restart   (restart),
        .load_byte (s_data.source_byte),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Output register: a finished byte is held here until its transfer.
    logic                 m_valid_reg;
    mr180_pkg::out_item_t m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result is never pushed over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result overwrote an unclaimed output byte");

    // A fetch keeps the input side closed while its reads are in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.opcode == mr180_pkg::OP_FETCH)) |=> !s_ready)
        else $error("input accepted during a fetch");

    // Output valid only rises right after a fetch completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("output valid without a completed fetch");

endmodule
`default_nettype wire

/* tb/tb_mask_rotate_180.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mask_rotate_180
// Self-checking bench for the 180-degree glyph mask rotator.
// ----------------------------------------------------------------------------
// A behavioral copy of the rotator runs next to the block. It tracks the
// source store, the load and fetch positions and the three registers, and
// works out every fetched byte as each input transfer is accepted. Results
// are matched in order against that copy. Short directed frames cover the
// byte extremes, the two mono bit orders, padding bytes, excess loads, the
// frame wrap, the fourth mode code, saturated dimensions and a write to the
// unused register index. Random frames then follow, mostly complete ones,
// with some cut short and some loose noise, while both channels idle.
// ----------------------------------------------------------------------------
module tb_mask_rotate_180;

    localparam int CFG_IDX_W = mr180_pkg::CFG_IDX_W;
    localparam int DIM_W     = mr180_pkg::DIM_W;
    localparam int MODE_W    = mr180_pkg::MODE_W;

    // Largest window side; the store holds one full window of bytes.
    localparam int unsigned MASK_MAX    = 256;
    localparam int unsigned STORE_DEPTH = MASK_MAX * MASK_MAX;
    // Idle wait after draining, so that any untracked load has settled
    // inside the block before a register write.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned ITEM_GOAL   = 1950;
    // Items that one frame with a side at its limit can take, with margin.
    localparam int unsigned BIG_FRAME_ITEMS = 1100;

    typedef enum int {
        FRAME_FULL,
        FRAME_CUT,
        FRAME_NOISE
    } frame_kind_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs. Every input has a known value
    // from time zero on.
    // ------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    mr180_pkg::in_item_t  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    mr180_pkg::out_item_t m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    mask_rotate_180 #(
        .MAX_WIDTH (MASK_MAX),
        .MAX_HEIGHT(MASK_MAX)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Behavioral copy of the rotator. The store is never cleared, just as
    // in the block, so a second bit per entry remembers whether it has
    // been written since reset. Fetches that would read an entry that was
    // never written are not generated.
    // ------------------------------------------------------------------
    bit [7:0]          src_mem     [STORE_DEPTH];
    bit                src_written [STORE_DEPTH];
    int unsigned       load_pos  = 0;
    int unsigned       fetch_pos = 0;
    logic [MODE_W-1:0] cur_mode  = mr180_pkg::MODE_ALPHA;
    int unsigned       cur_w     = 1;
    int unsigned       cur_h     = 1;

    // Rotated bytes that the block still owes, oldest first.
    mr180_pkg::out_item_t due_bytes[$];

    int unsigned fail_count      = 0;
    int unsigned items_sent      = 0;
    int unsigned fetches_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned frames_run      = 0;
    int unsigned reg_writes      = 0;
    int unsigned burst_left      = 0;

    function automatic bit mono_mode();
        return (cur_mode == mr180_pkg::MODE_MONO_MSB) ||
               (cur_mode == mr180_pkg::MODE_MONO_LSB);
    endfunction

    function automatic int unsigned source_row_bytes();
        return mono_mode() ? (cur_w + 7) / 8 : cur_w;
    endfunction

    // Computes output byte number pos of the turned window. The return value
    // tells whether every source byte it depends on has been written.
    function automatic bit turned_byte(input int unsigned pos, output logic [7:0] val);
        int unsigned y, x, sy, rb, ox, ix, addr, bitpos, k;
        bit          ok;
        y   = pos / cur_w;
        x   = pos % cur_w;
        sy  = cur_h - 1 - y;
        ok  = 1'b1;
        val = '0;
        if (!mono_mode()) begin
            addr = sy * cur_w + (cur_w - 1 - x);
            val  = src_mem[addr];
            return src_written[addr];
        end
        rb = (cur_w + 7) / 8;
        // Bytes past the packed part of a mono row are padding.
        if (x >= rb) begin
            return 1'b1;
        end
        for (k = 0; k < 8; k++) begin
            ox = x * 8 + k;
            if (ox < cur_w) begin
                ix     = cur_w - 1 - ox;
                addr   = sy * rb + ix / 8;
                ok     = ok & src_written[addr];
                bitpos = (cur_mode == mr180_pkg::MODE_MONO_MSB) ? 7 - (ix % 8) : ix % 8;
                if (src_mem[addr][bitpos]) begin
                    val[(cur_mode == mr180_pkg::MODE_MONO_MSB) ? 7 - k : k] = 1'b1;
                end
            end
        end
        return ok;
    endfunction

    function automatic bit next_fetch_defined();
        logic [7:0]  unused;
        int unsigned pos;
        pos = (fetch_pos >= cur_w * cur_h) ? 0 : fetch_pos;
        return turned_byte(pos, unused);
    endfunction

    function automatic void track_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] val);
        int unsigned dim;
        dim = (val == 0) ? 1 : ((val > MASK_MAX) ? MASK_MAX : val);
        case (idx)
            mr180_pkg::REG_MODE: begin
                cur_mode = val[MODE_W-1:0];
            end
            mr180_pkg::REG_WIDTH: begin
                cur_w = dim;
            end
            mr180_pkg::REG_HEIGHT: begin
                cur_h = dim;
            end
            // The unused index changes nothing, not even the positions.
            default: begin
                return;
            end
        endcase
        load_pos  = 0;
        fetch_pos = 0;
    endfunction

    function automatic void track_item(input mr180_pkg::in_item_t item);
        mr180_pkg::out_item_t res;
        logic [7:0]           b;
        int unsigned          total;
        total = cur_w * cur_h;
        if (item.opcode == mr180_pkg::OP_LOAD) begin
            // Loads past the end of the source window are dropped.
            if (load_pos < source_row_bytes() * cur_h) begin
                src_mem[load_pos]     = item.source_byte;
                src_written[load_pos] = 1'b1;
                load_pos++;
            end
            return;
        end
        if (fetch_pos >= total) begin
            fetch_pos = 0;
        end
        void'(turned_byte(fetch_pos, b));
        res.out_byte  = b;
        res.last_byte = (fetch_pos == total - 1);
        // The final byte of a frame rewinds both positions for the next mask.
        if (res.last_byte) begin
            fetch_pos = 0;
            load_pos  = 0;
        end else begin
            fetch_pos++;
        end
        due_bytes.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Items go out in bursts of random length; before each
    // burst the sender may sit idle for a random pause, or not at all. Valid
    // stays high from one item to the next inside a burst.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] byte_val);
        mr180_pkg::in_item_t item;
        int unsigned         pause;
        item.opcode      = op;
        item.source_byte = byte_val;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            pause      = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0) begin
                s_valid <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        track_item(item);
        items_sent++;
        if (op == mr180_pkg::OP_FETCH) begin
            fetches_sent++;
        end
    endtask

    // Holds the input channel idle until every owed byte has been seen,
    // then lets any trailing load finish inside the block.
    task automatic drain();
        s_valid    <= 1'b0;
        burst_left  = 0;
        @(posedge aclk);
        while (due_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write. The enable drops for a cycle afterwards so that
    // two writes in a row never touch the enable twice in one time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        track_reg(idx, val);
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_window(input logic [DIM_W-1:0] mode_val,
                              input logic [DIM_W-1:0] width_val,
                              input logic [DIM_W-1:0] height_val);
        write_reg(mr180_pkg::REG_MODE, mode_val);
        write_reg(mr180_pkg::REG_WIDTH, width_val);
        write_reg(mr180_pkg::REG_HEIGHT, height_val);
    endtask

    // ------------------------------------------------------------------
    // Receiver side. The stall rate changes after each random stretch, from
    // never stalling up to stalling most of the time.
    // ------------------------------------------------------------------
    int unsigned stall_pct   = 0;
    int unsigned stall_phase = 0;

    always @(posedge aclk) begin
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_phase = $urandom_range(16, 128);
        end
        stall_phase--;
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: every result transfer is compared with the oldest
    // byte still owed.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        mr180_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_bytes.size() == 0) begin
                $error("result with nothing owed: out_byte %02h last_byte %0b",
                       m_data.out_byte, m_data.last_byte);
                fail_count++;
            end else begin
                want = due_bytes.pop_front();
                results_checked++;
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_data.out_byte);
                    fail_count++;
                end
                if (m_data.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", want.last_byte,
                           m_data.last_byte);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a long stretch without any transfer means the block hung.
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // A two-pixel alpha row with the byte extremes. The third load lands
    // past the window and must be dropped. The third fetch wraps into the
    // next frame and reads the bytes still sitting in the store.
    task automatic test_alpha_edges();
        drain();
        set_window(DIM_W'(mr180_pkg::MODE_ALPHA), 9'd2, 9'd1);
        send_item(mr180_pkg::OP_LOAD, 8'h00);
        send_item(mr180_pkg::OP_LOAD, 8'hFF);
        send_item(mr180_pkg::OP_LOAD, 8'h80);
        repeat (3) send_item(mr180_pkg::OP_FETCH, 8'($urandom));
    endtask

    // Nine MSB-first pixels span two source bytes; the third output byte is
    // row padding and must be zero. The frame is left unfinished on purpose.
    task automatic test_mono_msb_rows();
        drain();
        set_window(DIM_W'(mr180_pkg::MODE_MONO_MSB), 9'd9, 9'd1);
        send_item(mr180_pkg::OP_LOAD, 8'hA5);
        send_item(mr180_pkg::OP_LOAD, 8'h80);
        repeat (3) send_item(mr180_pkg::OP_FETCH, 8'($urandom));
    endtask

    // LSB-first, two rows of three pixels. A write to the unused register
    // index lands between the loads and must not rewind the load position.
    task automatic test_mono_lsb_unlisted_reg();
        drain();
        set_window(DIM_W'(mr180_pkg::MODE_MONO_LSB), 9'd3, 9'd2);
        send_item(mr180_pkg::OP_LOAD, 8'h01);
        drain();
        write_reg(2'd3, DIM_W'($urandom));
        send_item(mr180_pkg::OP_LOAD, 8'hFE);
        repeat (6) send_item(mr180_pkg::OP_FETCH, 8'($urandom));
    endtask

    // The fourth mode code acts as alpha, and zero dimensions become one.
    task automatic test_mode_alias_min();
        drain();
        set_window(DIM_W'(2'd3), 9'd0, 9'd0);
        send_item(mr180_pkg::OP_LOAD, 8'h7E);
        send_item(mr180_pkg::OP_FETCH, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Random frames.
    // ------------------------------------------------------------------

    // Register value for a window side; the ends are sometimes reached
    // through values that the block has to saturate.
    function automatic logic [DIM_W-1:0] dim_code(input int unsigned dim);
        if (dim == 1 && $urandom_range(0, 3) == 0) begin
            return '0;
        end
        if (dim == MASK_MAX && $urandom_range(0, 1) == 0) begin
            return DIM_W'($urandom_range(MASK_MAX + 1, (1 << DIM_W) - 1));
        end
        return DIM_W'(dim);
    endfunction

    // Reprograms the window and then mixes loads and fetches. A fetch goes
    // out only when the store already holds every byte it reads, so early
    // fetches see stale bytes from earlier frames where those exist.
    task automatic run_mask_frame(input logic [MODE_W-1:0] mode, input int unsigned w,
                                  input int unsigned h, input frame_kind_t kind);
        logic [DIM_W-1:0] mode_val;
        int unsigned      loads_left, fetches_left, n_load, n_out, lead;
        drain();
        mode_val = DIM_W'(mode);
        if ($urandom_range(0, 7) == 0) begin
            mode_val[DIM_W-1:MODE_W] = (DIM_W - MODE_W)'($urandom);
        end
        set_window(mode_val, dim_code(w), dim_code(h));
        n_load = source_row_bytes() * cur_h;
        n_out  = cur_w * cur_h;
        case (kind)
            FRAME_FULL: begin
                loads_left   = n_load + $urandom_range(0, 2);
                fetches_left = n_out;
            end
            FRAME_CUT: begin
                loads_left   = $urandom_range(0, n_load);
                fetches_left = $urandom_range(1, (n_out < 48) ? n_out : 48);
            end
            default: begin
                loads_left   = $urandom_range(0, 6);
                fetches_left = $urandom_range(0, 6);
            end
        endcase
        lead = $urandom_range(0, 100);
        while (loads_left + fetches_left != 0) begin
            if (fetches_left != 0 && next_fetch_defined()
                && (loads_left == 0 || $urandom_range(0, 99) < lead)) begin
                send_item(mr180_pkg::OP_FETCH, 8'($urandom));
                fetches_left--;
            end else if (loads_left != 0) begin
                send_item(mr180_pkg::OP_LOAD, 8'($urandom));
                loads_left--;
            end else begin
                break;
            end
        end
        frames_run++;
    endtask

    task automatic test_random_frames();
        int unsigned       w, h, pick;
        frame_kind_t       kind;
        logic [MODE_W-1:0] mode;
        while (items_sent < ITEM_GOAL) begin
            mode = MODE_W'($urandom_range(0, 3));
            // Most windows are small; now and then one side is at its limit,
            // as long as such a frame still fits in the remaining item count.
            if ($urandom_range(0, 11) == 0 && ITEM_GOAL - items_sent > BIG_FRAME_ITEMS) begin
                if ($urandom_range(0, 1) == 0) begin
                    w = MASK_MAX;
                    h = $urandom_range(1, 2);
                end else begin
                    w = 1;
                    h = MASK_MAX;
                end
            end else begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 6);
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? FRAME_FULL : ((pick < 9) ? FRAME_CUT : FRAME_NOISE);
            run_mask_frame(mode, w, h, kind);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_alpha_edges();
        test_mono_msb_rows();
        test_mono_lsb_unlisted_reg();
        test_mode_alias_min();
        test_random_frames();
        drain();
        $display("Rotated %0d frames in all four mode codes: %0d transfers, %0d fetches,",
                 frames_run + 4, items_sent, fetches_sent);
        $display("%0d result bytes compared, %0d register writes, %0d mismatches.",
                 results_checked, reg_writes, fail_count);
        if (fail_count == 0 && due_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
